// ===== sv/mlpbp_pkg.sv =====
package mlpbp_pkg;

    localparam int NUM_W = 17;
    localparam int NUM_HW = 9;
    localparam int FRAC_BITS = 12;
    localparam logic signed [16:0] FX_ONE = 17'sd4096;
    localparam logic signed [16:0] LEAK_SLOPE = 17'sd819;
    localparam logic [11:0] LR_RESET = 12'd819;

    localparam logic [1:0] OP_TRAIN = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic CFG_LEARN_RATE = 1'b0;
    localparam logic CFG_ACT_MODE = 1'b1;

    // Hidden weights first (bias, a, b per unit), then output weights (bias, h0..h2).
    localparam logic signed [15:0] W_INIT [NUM_W] = '{
        16'sd1229, 16'sd410, 16'sd0,
        -16'sd819, 16'sd1229, 16'sd410,
        -16'sd410, 16'sd0, 16'sd819,
        16'sd819, 16'sd1229, -16'sd410, -16'sd410,
        -16'sd1229, 16'sd1638, 16'sd410, 16'sd819
    };
    localparam logic [1:0] W_ROW [NUM_W] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1
    };
    localparam logic [1:0] W_COL [NUM_W] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3
    };

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_FWD_MAC  = 12'b0000_0000_0010,
        S_FWD_RND  = 12'b0000_0000_0100,
        S_GATE_MUL = 12'b0000_0000_1000,
        S_GATE_RES = 12'b0000_0001_0000,
        S_ERR      = 12'b0000_0010_0000,
        S_BP_MAC   = 12'b0000_0100_0000,
        S_BP_RND   = 12'b0000_1000_0000,
        S_LR_MUL   = 12'b0001_0000_0000,
        S_UPD_MAC  = 12'b0010_0000_0000,
        S_UPD_WR   = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        P_HID  = 2'd0,
        P_OUT  = 2'd1,
        P_ODEL = 2'd2,
        P_HDEL = 2'd3
    } pass_t;

    typedef struct packed {
        logic en;
        logic load;
    } mac_ctl_t;

    function automatic logic signed [47:0] sx16(input logic signed [15:0] v);
        sx16 = {{32{v[15]}}, v};
    endfunction

    // Round half up to FRAC_BITS fraction bits.
    function automatic logic signed [47:0] rnd12(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = v + 48'sd2048;
        rnd12 = s >>> FRAC_BITS;
    endfunction

    function automatic logic signed [47:0] rnd24(input logic signed [47:0] v);
        logic signed [47:0] s;
        s = v + 48'sd8388608;
        rnd24 = s >>> (2 * FRAC_BITS);
    endfunction

    // Returns {clipped, value}.
    function automatic logic [16:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            sat16 = {1'b1, 16'h7fff};
        else if (v < -48'sd32768)
            sat16 = {1'b1, 16'h8000};
        else
            sat16 = {1'b0, v[15:0]};
    endfunction

endpackage

// ===== sv/mlpbp_mac.sv =====
module mlpbp_mac
    import mlpbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mac_ctl_t            ctl,
    input  logic signed [29:0]  a,
    input  logic signed [16:0]  b,
    output logic signed [47:0]  acc
);

    logic signed [46:0] prod;
    logic signed [47:0] acc_reg;

    assign prod = a * b;
    assign acc = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctl.en)
        begin
            if (ctl.load)
                acc_reg <= {prod[46], prod};
            else
                acc_reg <= acc_reg + {prod[46], prod};
        end
    end

endmodule

// ===== sv/mlp_backprop_train_step.sv =====
// Online trainer for a 2-3-2 perceptron with saturating Q4.12 arithmetic.
// Input words arrive on s_tvalid/s_tready; tuser carries the operation
// (train, predict, write weight) and tdata the features, targets and the
// weight to load. Every input word gives exactly one result word on
// m_tvalid/m_tready with both network outputs and a saturation flag.
// All arithmetic runs through one 30x17 multiply-accumulate unit under a
// small sequencer, one product per cycle. Predict runs the forward pass;
// train adds error, back-propagation and a pass rewriting all 17 weights,
// three steps each (learn-rate multiply, update multiply, write). Writes
// and NOPs go to done. s_tready is high only while the sequencer idles.
// The result sits in an output register, so a new word is accepted while
// the last result is still waiting; if the receiver stalls, the sequencer
// holds its finished result until the output register frees up.
// Reset loads the initial weights, learn rate 819 and plain ReLU.
// Configuration registers (learn rate, activation mode) are written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.
module mlp_backprop_train_step
    import mlpbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // feature_a, feature_b, target_a, target_b, weight_index, weight_value, pad
    input  logic [87:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // net_out_a, net_out_b, saturated, pad
    output logic [39:0] m_tdata
);

    state_t state_reg, state_next;
    pass_t  pass_reg;
    logic [1:0] u_reg, k_reg;
    logic [4:0] widx_reg;
    logic signed [15:0] w_reg [NUM_W];
    logic [11:0] lr_reg;
    logic mode_reg, train_reg, clip_reg;
    logic signed [15:0] x_reg [2];
    logic signed [15:0] tgt_reg [2];
    logic signed [15:0] hpre_reg [3];
    logic signed [15:0] hout_reg [3];
    logic signed [15:0] opre_reg [2];
    logic signed [15:0] oout_reg [2];
    logic signed [15:0] odel_reg [2];
    logic signed [15:0] hdel_reg [3];
    logic signed [15:0] gv_reg;
    logic gneg_reg;
    logic out_valid_reg;
    logic [32:0] out_data_reg;

    logic [4:0] rd_idx;
    logic signed [15:0] w_rd;
    mac_ctl_t mac_ctl;
    logic signed [29:0] mac_a;
    logic signed [16:0] mac_b;
    logic signed [47:0] acc;
    logic [16:0] sat_r12, sat_err, sat_upd;
    logic signed [47:0] r12;
    logic signed [15:0] gres, delta_sel, in_x;
    logic [1:0] k_m1, wcol, wrow;
    logic last_k, out_free, accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_data_reg};

    always_comb
    begin
        unique case (state_reg)
            S_FWD_MAC: rd_idx = (pass_reg == P_HID) ? 5'(u_reg) * 5'd3 + 5'(k_reg)
                                                    : 5'(5'd9 + u_reg * 3'd4 + k_reg);
            S_BP_MAC:  rd_idx = 5'(5'd10 + k_reg * 3'd4 + u_reg);
            default:   rd_idx = widx_reg;
        endcase
    end

    assign w_rd = w_reg[rd_idx];
    assign k_m1 = k_reg - 2'd1;
    assign wrow = W_ROW[widx_reg];
    assign wcol = W_COL[widx_reg];
    assign last_k = (pass_reg == P_HID) ? (k_reg == 2'd2) : (k_reg == 2'd3);

    assign r12 = rnd12(acc);
    assign sat_r12 = sat16(r12);
    assign sat_err = sat16(sx16(tgt_reg[u_reg[0]]) - sx16(oout_reg[u_reg[0]]));
    assign sat_upd = sat16(sx16(w_rd) + rnd24(acc));
    assign gres = !gneg_reg ? gv_reg : (mode_reg ? r12[15:0] : 16'sd0);

    always_comb
    begin
        delta_sel = (widx_reg < 5'(NUM_HW)) ? hdel_reg[wrow] : odel_reg[wrow[0]];
        if (widx_reg < 5'(NUM_HW))
            in_x = (wcol == 2'd1) ? x_reg[0] : x_reg[1];
        else
            in_x = hout_reg[wcol - 2'd1];
    end

    always_comb
    begin
        mac_ctl = '{en: 1'b0, load: 1'b1};
        mac_a = '0;
        mac_b = '0;
        unique case (state_reg)
            S_FWD_MAC:
            begin
                mac_ctl = '{en: 1'b1, load: (k_reg == 2'd0)};
                mac_a = 30'(w_rd);
                if (k_reg == 2'd0)
                    mac_b = FX_ONE;
                else if (pass_reg == P_HID)
                    mac_b = 17'(x_reg[k_m1[0]]);
                else
                    mac_b = 17'(hout_reg[k_m1]);
            end
            S_GATE_MUL:
            begin
                mac_ctl = '{en: 1'b1, load: 1'b1};
                mac_a = 30'(gv_reg);
                mac_b = LEAK_SLOPE;
            end
            S_BP_MAC:
            begin
                mac_ctl = '{en: 1'b1, load: (k_reg == 2'd0)};
                mac_a = 30'(w_rd);
                mac_b = 17'(odel_reg[k_reg[0]]);
            end
            S_LR_MUL:
            begin
                mac_ctl = '{en: 1'b1, load: 1'b1};
                mac_a = 30'(delta_sel);
                mac_b = {5'd0, lr_reg};
            end
            S_UPD_MAC:
            begin
                // The learn rate times delta fits in 28 signed bits.
                mac_ctl = '{en: 1'b1, load: 1'b1};
                mac_a = acc[29:0];
                mac_b = (wcol == 2'd0) ? FX_ONE : 17'(in_x);
            end
            default:
            begin
                mac_ctl = '{en: 1'b0, load: 1'b1};
            end
        endcase
    end

    mlpbp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = (s_tuser == OP_TRAIN || s_tuser == OP_PREDICT)
                                 ? S_FWD_MAC : S_DONE;
            end
            S_FWD_MAC:  state_next = last_k ? S_FWD_RND : S_FWD_MAC;
            S_FWD_RND:  state_next = S_GATE_MUL;
            S_GATE_MUL: state_next = S_GATE_RES;
            S_GATE_RES:
            begin
                unique case (pass_reg)
                    P_HID:  state_next = S_FWD_MAC;
                    P_OUT:  state_next = (u_reg != 2'd1) ? S_FWD_MAC
                                       : (train_reg ? S_ERR : S_DONE);
                    P_ODEL: state_next = (u_reg == 2'd1) ? S_BP_MAC : S_ERR;
                    P_HDEL: state_next = (u_reg == 2'd2) ? S_LR_MUL : S_BP_MAC;
                    default: state_next = S_IDLE;
                endcase
            end
            S_ERR:      state_next = S_GATE_MUL;
            S_BP_MAC:   state_next = (k_reg == 2'd1) ? S_BP_RND : S_BP_MAC;
            S_BP_RND:   state_next = S_GATE_MUL;
            S_LR_MUL:   state_next = S_UPD_MAC;
            S_UPD_MAC:  state_next = S_UPD_WR;
            S_UPD_WR:   state_next = (widx_reg == 5'(NUM_W - 1)) ? S_DONE : S_LR_MUL;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg <= P_HID;
            u_reg <= '0;
            k_reg <= '0;
            widx_reg <= '0;
            lr_reg <= LR_RESET;
            mode_reg <= 1'b0;
            train_reg <= 1'b0;
            clip_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_W; i++)
                w_reg[i] <= W_INIT[i];
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == CFG_LEARN_RATE)
                    lr_reg <= cfg_data;
                else
                    mode_reg <= cfg_data[0];
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        x_reg[0] <= s_tdata[15:0];
                        x_reg[1] <= s_tdata[31:16];
                        tgt_reg[0] <= s_tdata[47:32];
                        tgt_reg[1] <= s_tdata[63:48];
                        clip_reg <= 1'b0;
                        pass_reg <= P_HID;
                        u_reg <= '0;
                        k_reg <= '0;
                        widx_reg <= '0;
                        train_reg <= (s_tuser == OP_TRAIN);
                        oout_reg[0] <= '0;
                        oout_reg[1] <= '0;
                        if (s_tuser == OP_WRITE && s_tdata[68:64] < 5'(NUM_W))
                            w_reg[s_tdata[68:64]] <= s_tdata[84:69];
                    end
                end
                S_FWD_MAC:
                begin
                    k_reg <= last_k ? 2'd0 : k_reg + 2'd1;
                end
                S_FWD_RND:
                begin
                    clip_reg <= clip_reg | sat_r12[16];
                    gv_reg <= sat_r12[15:0];
                    gneg_reg <= sat_r12[15];
                    if (pass_reg == P_HID)
                        hpre_reg[u_reg] <= sat_r12[15:0];
                    else
                        opre_reg[u_reg[0]] <= sat_r12[15:0];
                end
                S_GATE_RES:
                begin
                    unique case (pass_reg)
                        P_HID:
                        begin
                            hout_reg[u_reg] <= gres;
                            if (u_reg == 2'd2)
                            begin
                                pass_reg <= P_OUT;
                                u_reg <= '0;
                            end
                            else
                                u_reg <= u_reg + 2'd1;
                        end
                        P_OUT:
                        begin
                            oout_reg[u_reg[0]] <= gres;
                            if (u_reg == 2'd1)
                            begin
                                pass_reg <= P_ODEL;
                                u_reg <= '0;
                            end
                            else
                                u_reg <= u_reg + 2'd1;
                        end
                        P_ODEL:
                        begin
                            odel_reg[u_reg[0]] <= gres;
                            if (u_reg == 2'd1)
                            begin
                                pass_reg <= P_HDEL;
                                u_reg <= '0;
                            end
                            else
                                u_reg <= u_reg + 2'd1;
                        end
                        P_HDEL:
                        begin
                            hdel_reg[u_reg] <= gres;
                            u_reg <= (u_reg == 2'd2) ? 2'd0 : u_reg + 2'd1;
                        end
                        default:
                        begin
                            u_reg <= '0;
                        end
                    endcase
                end
                S_ERR:
                begin
                    clip_reg <= clip_reg | sat_err[16];
                    gv_reg <= sat_err[15:0];
                    gneg_reg <= opre_reg[u_reg[0]][15];
                end
                S_BP_MAC:
                begin
                    k_reg <= (k_reg == 2'd1) ? 2'd0 : k_reg + 2'd1;
                end
                S_BP_RND:
                begin
                    // Hidden deltas see the output weights before any update.
                    clip_reg <= clip_reg | sat_r12[16];
                    gv_reg <= sat_r12[15:0];
                    gneg_reg <= hpre_reg[u_reg][15];
                end
                S_UPD_WR:
                begin
                    clip_reg <= clip_reg | sat_upd[16];
                    w_reg[widx_reg] <= sat_upd[15:0];
                    widx_reg <= widx_reg + 5'd1;
                end
                S_DONE:
                begin
                    if (out_free)
                        out_data_reg <= {clip_reg, oout_reg[1], oout_reg[0]};
                end
                default:
                begin
                end
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_upd_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD_WR) |-> (widx_reg < 5'(NUM_W)))
        else $error("weight update index out of range");

    a_fwd_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_TRAIN || s_tuser == OP_PREDICT))
        |=> (state_reg == S_FWD_MAC && k_reg == 2'd0 && pass_reg == P_HID))
        else $error("forward pass did not start after accept");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside the done step");

    a_train_only_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR || state_reg == S_LR_MUL) |-> train_reg)
        else $error("training step reached on a predict word");

endmodule
